[hdl/xcr_pkg.sv]
// package: types, constants and functions shared by the receiver modules
`timescale 1ns / 1ps
package xcr_pkg;

    localparam int LONG_PACKET_BYTES = 1024;
    localparam int SHORT_PACKET_BYTES = 128;
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W = 3;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_COMMIT  = 3'd2;
    localparam logic [2:0] KIND_DISCARD = 3'd3;
    localparam logic [2:0] KIND_FINISH  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_REMOTE  = 3'd1;
    localparam logic [2:0] ST_SYNC    = 3'd2;
    localparam logic [2:0] ST_RETRY   = 3'd3;
    localparam logic [2:0] ST_UNEXPEC = 3'd4;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY   = 2'd1;
    localparam logic [1:0] REG_LONG    = 2'd2;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_SOLICIT = 8'h43;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_START, PH_WAIT_CAN2, PH_PACKET, PH_FLUSH
    } phase_t;

    typedef enum logic [2:0] {
        AF_NONE, AF_SOLICIT, AF_EOT, AF_REMOTE, AF_SYNC, AF_RETRY
    } flush_act_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [9:0]  offset;
        logic [2:0]  status;
        logic [31:0] total_bytes;
        logic        last;
    } out_word_t;

    // group of results produced by one input word
    typedef struct packed {
        logic [RES_CNT_W-1:0]     count;
        out_word_t [MAX_RESULTS-1:0] res;
    } res_group_t;

    typedef struct packed {
        logic [7:0] timeout_ticks;
        logic [6:0] retry_limit;
        logic       allow_long;
    } cfg_t;

    // one byte of crc-16 with polynomial 0x1021, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hdl/xcr_engine.sv]
// protocol engine: session state and the result words of one input word
`timescale 1ns / 1ps
module xcr_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  xcr_pkg::cfg_t     cfg,
    input  logic              in_valid,
    input  xcr_pkg::in_word_t in_word,
    output xcr_pkg::res_group_t group
);
    import xcr_pkg::*;

    localparam int POS_W = 11;

    phase_t      phase_reg, phase_next;
    flush_act_t  act_reg, act_next;
    logic [7:0]  reply_reg, reply_next;
    logic [7:0]  exp_seq_reg, exp_seq_next;
    logic [6:0]  retries_reg, retries_next;
    logic        crc_mode_reg, crc_mode_next;
    logic        long_reg, long_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  silence_reg, silence_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  seqc_reg, seqc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] rchk_reg, rchk_next;
    logic [31:0] total_reg, total_next;

    logic [RES_CNT_W-1:0] n;
    out_word_t [MAX_RESULTS-1:0] res;

    // combinational step over one input word
    always_comb begin
        logic [POS_W-1:0] pk;
        logic [POS_W-1:0] pos;
        logic [31:0] sum33;
        logic        seq_ok, chk_ok, do_end, do_abort, do_solicit, do_flush_done;
        logic [7:0]  sil;
        flush_act_t  fa;
        logic [RES_CNT_W-1:0] n_last;
        phase_next = phase_reg;  act_next = act_reg;  reply_next = reply_reg;
        exp_seq_next = exp_seq_reg;  retries_next = retries_reg;
        crc_mode_next = crc_mode_reg;  long_next = long_reg;  pos_next = pos_reg;
        silence_next = silence_reg;  seq_next = seq_reg;  seqc_next = seqc_reg;
        crc_next = crc_reg;  sum_next = sum_reg;  rchk_next = rchk_reg;
        total_next = total_reg;
        n = '0;
        n_last = '0;
        res = '0;
        do_end = 1'b0;  do_abort = 1'b0;  do_solicit = 1'b0;  do_flush_done = 1'b0;
        pk = long_reg ? POS_W'(LONG_PACKET_BYTES) : POS_W'(SHORT_PACKET_BYTES);
        pos = pos_reg;
        sil = 8'd0;
        fa = act_reg;
        sum33 = 32'd0;
        seq_ok = 1'b0;
        chk_ok = 1'b0;

        if (in_valid) begin
            case (in_word.op)
                OP_START: begin
                    reply_next = B_SOLICIT;  exp_seq_next = 8'd1;
                    retries_next = cfg.retry_limit;  crc_mode_next = 1'b0;
                    long_next = 1'b0;  pos_next = '0;  silence_next = '0;
                    seq_next = '0;  seqc_next = '0;  crc_next = '0;  sum_next = '0;
                    rchk_next = '0;  act_next = AF_NONE;  total_next = '0;
                    phase_next = PH_IDLE;
                    do_solicit = 1'b1;
                end
                OP_BYTE: begin
                    if (phase_reg != PH_IDLE) silence_next = '0;
                    case (phase_reg)
                        PH_WAIT_START: begin
                            if (in_word.rx_byte == B_SOH ||
                                (in_word.rx_byte == B_STX && cfg.allow_long)) begin
                                long_next = (in_word.rx_byte == B_STX);
                                if (reply_reg == B_SOLICIT) crc_mode_next = 1'b1;
                                pos_next = '0;  crc_next = '0;  sum_next = '0;
                                rchk_next = '0;  seq_next = '0;  seqc_next = '0;
                                phase_next = PH_PACKET;
                            end else if (in_word.rx_byte == B_EOT) begin
                                phase_next = PH_FLUSH;  act_next = AF_EOT;
                            end else if (in_word.rx_byte == B_CAN) begin
                                phase_next = PH_WAIT_CAN2;
                            end else begin
                                res[0].kind = KIND_FINISH;  res[0].status = ST_UNEXPEC;
                                res[0].total_bytes = total_reg;  n = 3'd1;
                                phase_next = PH_IDLE;  act_next = AF_NONE;
                            end
                        end
                        PH_WAIT_CAN2: begin
                            if (in_word.rx_byte == B_CAN) begin
                                phase_next = PH_FLUSH;  act_next = AF_REMOTE;
                            end else begin
                                res[0].kind = KIND_FINISH;  res[0].status = ST_UNEXPEC;
                                res[0].total_bytes = total_reg;  n = 3'd1;
                                phase_next = PH_IDLE;  act_next = AF_NONE;
                            end
                        end
                        PH_PACKET: begin
                            if (pos == '0) seq_next = in_word.rx_byte;
                            else if (pos == POS_W'(1)) seqc_next = in_word.rx_byte;
                            else if (pos < pk + POS_W'(2)) begin
                                res[0].kind = KIND_PAYLOAD;
                                res[0].value = in_word.rx_byte;
                                res[0].offset = 10'(pos - POS_W'(2));
                                n = 3'd1;
                                crc_next = crc_byte(crc_reg, in_word.rx_byte);
                                sum_next = sum_reg + in_word.rx_byte;
                            end else begin
                                rchk_next = {rchk_reg[7:0], in_word.rx_byte};
                            end
                            pos_next = pos + POS_W'(1);
                            if (pos_next >= pk + POS_W'(3) + POS_W'(crc_mode_reg))
                                do_end = 1'b1;
                        end
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        sil = (silence_reg != 8'hFF) ? silence_reg + 8'd1 : silence_reg;
                        silence_next = sil;
                        if (sil >= cfg.timeout_ticks) begin
                            silence_next = '0;
                            case (phase_reg)
                                PH_WAIT_START: begin
                                    if (retries_reg != '0) retries_next = retries_reg - 7'd1;
                                    do_solicit = 1'b1;
                                end
                                PH_WAIT_CAN2: begin
                                    res[0].kind = KIND_FINISH;  res[0].status = ST_UNEXPEC;
                                    res[0].total_bytes = total_reg;  n = 3'd1;
                                    phase_next = PH_IDLE;  act_next = AF_NONE;
                                end
                                PH_PACKET: do_abort = 1'b1;
                                PH_FLUSH: do_flush_done = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase

            // end of packet: checks and sequence handling
            if (do_end) begin
                seq_ok = (seq_next == ~seqc_next);
                chk_ok = crc_mode_next ? (crc_next == rchk_next)
                                       : (sum_next == rchk_next[7:0]);
                if (!(seq_ok && chk_ok)) begin
                    do_abort = 1'b1;
                end else if (seq_next == exp_seq_reg) begin
                    res[n[1:0]].kind = KIND_COMMIT;  n = n + 3'd1;
                    sum33 = total_reg + 32'(pk);
                    total_next = (sum33 < total_reg) ? 32'hFFFF_FFFF : sum33;
                    exp_seq_next = exp_seq_reg + 8'd1;
                    retries_next = cfg.retry_limit;
                    reply_next = B_ACK;
                    do_solicit = 1'b1;
                end else if (seq_next == exp_seq_reg - 8'd1) begin
                    res[n[1:0]].kind = KIND_DISCARD;  n = n + 3'd1;
                    reply_next = B_ACK;
                    do_solicit = 1'b1;
                end else begin
                    res[n[1:0]].kind = KIND_DISCARD;  n = n + 3'd1;
                    phase_next = PH_FLUSH;  silence_next = '0;  act_next = AF_SYNC;
                end
            end

            // packet abort: discard, use a retry, flush then nak
            if (do_abort) begin
                res[n[1:0]].kind = KIND_DISCARD;  n = n + 3'd1;
                if (retries_reg != '0) retries_next = retries_reg - 7'd1;
                reply_next = B_NAK;
                phase_next = PH_FLUSH;  silence_next = '0;  act_next = AF_SOLICIT;
            end

            // line has gone quiet after a flush
            if (do_flush_done) begin
                act_next = AF_NONE;
                case (fa)
                    AF_SOLICIT: do_solicit = 1'b1;
                    AF_EOT, AF_REMOTE: begin
                        res[0].kind = KIND_SEND;  res[0].value = B_ACK;
                        res[1].kind = KIND_FINISH;
                        res[1].status = (fa == AF_EOT) ? ST_OK : ST_REMOTE;
                        res[1].total_bytes = total_reg;  n = 3'd2;
                        phase_next = PH_IDLE;
                    end
                    AF_SYNC, AF_RETRY: begin
                        for (int i = 0; i < 3; i++) begin
                            res[i].kind = KIND_SEND;  res[i].value = B_CAN;
                        end
                        res[3].kind = KIND_FINISH;
                        res[3].status = (fa == AF_SYNC) ? ST_SYNC : ST_RETRY;
                        res[3].total_bytes = total_reg;  n = 3'd4;
                        phase_next = PH_IDLE;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end

            // send the reply byte, or give up when no retries remain
            if (do_solicit) begin
                if (retries_next == '0) begin
                    phase_next = PH_FLUSH;  silence_next = '0;  act_next = AF_RETRY;
                end else begin
                    res[n[1:0]].kind = KIND_SEND;  res[n[1:0]].value = reply_next;
                    n = n + 3'd1;
                    phase_next = PH_WAIT_START;  silence_next = '0;
                end
            end

            if (n != '0) begin
                n_last = n - 3'd1;
                res[n_last[1:0]].last = 1'b1;
            end
        end
    end

    // session state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;  act_reg <= AF_NONE;  reply_reg <= B_SOLICIT;
            exp_seq_reg <= 8'd1;  retries_reg <= 7'd32;  crc_mode_reg <= 1'b0;
            long_reg <= 1'b0;  pos_reg <= '0;  silence_reg <= '0;  seq_reg <= '0;
            seqc_reg <= '0;  crc_reg <= '0;  sum_reg <= '0;  rchk_reg <= '0;
            total_reg <= '0;
        end else begin
            phase_reg <= phase_next;  act_reg <= act_next;  reply_reg <= reply_next;
            exp_seq_reg <= exp_seq_next;  retries_reg <= retries_next;
            crc_mode_reg <= crc_mode_next;  long_reg <= long_next;  pos_reg <= pos_next;
            silence_reg <= silence_next;  seq_reg <= seq_next;  seqc_reg <= seqc_next;
            crc_reg <= crc_next;  sum_reg <= sum_next;  rchk_reg <= rchk_next;
            total_reg <= total_next;
        end
    end

    assign group.count = n;
    assign group.res = res;

endmodule

[hdl/xcr_out_queue.sv]
// result queue: holds result groups and plays them out one word at a time
`timescale 1ns / 1ps
module xcr_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  xcr_pkg::res_group_t group,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output xcr_pkg::out_word_t  m_word
);
    import xcr_pkg::*;

    // two slots of groups, with one read index shared by both
    res_group_t           slot_reg [2];
    logic [1:0]           full_reg;
    logic                 rd_reg, wr_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 pop_word, pop_group;

    assign m_valid   = full_reg[rd_reg];
    assign m_word    = slot_reg[rd_reg].res[idx_reg[1:0]];
    assign pop_word  = m_valid && m_ready;
    assign pop_group = pop_word && (idx_reg + 3'd1 == slot_reg[rd_reg].count);
    assign room      = !full_reg[wr_reg];

    // slot bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= '0;  rd_reg <= 1'b0;  wr_reg <= 1'b0;  idx_reg <= '0;
        end else begin
            if (push && group.count != '0) begin
                full_reg[wr_reg] <= 1'b1;
                wr_reg <= !wr_reg;
            end
            if (pop_group) begin
                full_reg[rd_reg] <= 1'b0;
                rd_reg <= !rd_reg;
                idx_reg <= '0;
            end else if (pop_word) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // group payload storage
    always_ff @(posedge aclk) begin
        if (push && group.count != '0) slot_reg[wr_reg] <= group;
    end

endmodule

[hdl/xmodem_crc_receiver_core.sv]
// top level of the xmodem crc receiver
`timescale 1ns / 1ps
// XMODEM receiving side (128-byte SOH and 1K STX packets, CRC-16 or byte sum).
// Each input word (start, received byte or timer tick) is handled by the
// protocol engine and yields up to four result words, which enter a two-group
// result queue and leave one per cycle on the m_ channel while m_ready is high.
// An input word is taken every cycle while the queue has a free group slot.
// Registers are written through cfg_we/cfg_index/cfg_data by the user only
// while the block is idle; the block itself does not enforce this.
module xmodem_crc_receiver_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  xcr_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output xcr_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import xcr_pkg::*;

    cfg_t       cfg_reg;
    res_group_t group;
    logic       room;
    logic       accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= 8'd100;
            cfg_reg.retry_limit   <= 7'd32;
            cfg_reg.allow_long    <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                REG_RETRY:   cfg_reg.retry_limit <= cfg_data[6:0];
                REG_LONG:    cfg_reg.allow_long <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    xcr_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(accept), .in_word(s_data), .group(group)
    );

    xcr_out_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(accept), .group(group),
        .room(room), .m_valid(m_valid), .m_ready(m_ready), .m_word(m_data)
    );

    // a result group never exceeds four words
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> group.count <= 3'd4) else $error("result group too large");

    // nothing accepted while the queue is full
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !room |-> !accept) else $error("input taken with no room");

    // the finished word is always the last of its group
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_FINISH) |-> m_data.last)
        else $error("finish word not last");

endmodule

[verif/tb_xmodem_crc_receiver_core.sv]
// testbench for the xmodem crc receiver core: random sessions checked against a predictor
`timescale 1ns / 1ps
module tb_xmodem_crc_receiver_core;
    import xcr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // predictor of the receiver plus the queue of expected result words
    class xmodem_scoreboard;
        out_word_t expected_q[$];
        out_word_t step_q[$];
        int errors = 0;
        int checked = 0;
        int sessions_done = 0;

        logic [7:0] timeout_ticks;
        logic [6:0] retry_limit;
        logic allow_long;

        phase_t phase;
        flush_act_t after_flush;
        logic [7:0] reply_byte, expected_seq, silence, seq_byte, seq_comp, sum_acc;
        logic [6:0] retries_left;
        logic crc_mode, long_packet;
        logic [10:0] byte_pos;
        logic [15:0] crc_acc, rx_check;
        logic [31:0] byte_total;

        function void clear_session();
            phase = PH_IDLE;
            reply_byte = B_SOLICIT;
            expected_seq = 8'd1;
            retries_left = retry_limit;
            crc_mode = 1'b0;
            long_packet = 1'b0;
            byte_pos = '0;
            silence = '0;
            seq_byte = '0;
            seq_comp = '0;
            crc_acc = '0;
            sum_acc = '0;
            rx_check = '0;
            after_flush = AF_NONE;
            byte_total = '0;
        endfunction

        function void reset_all();
            timeout_ticks = 8'd100;
            retry_limit = 7'd32;
            allow_long = 1'b1;
            clear_session();
            expected_q.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                REG_TIMEOUT: timeout_ticks = data;
                REG_RETRY: retry_limit = data[6:0];
                REG_LONG: allow_long = data[0];
                default: ;
            endcase
        endfunction

        function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            return c;
        endfunction

        function void emit(logic [2:0] kind, logic [7:0] value, logic [9:0] offset,
                           logic [2:0] status, logic [31:0] total);
            out_word_t r;
            r.kind = kind;
            r.value = value;
            r.offset = offset;
            r.status = status;
            r.total_bytes = total;
            r.last = 1'b0;
            if (step_q.size() < MAX_RESULTS) step_q.push_back(r);
        endfunction

        function void finish(logic [2:0] status);
            emit(KIND_FINISH, 8'd0, 10'd0, status, byte_total);
            phase = PH_IDLE;
            after_flush = AF_NONE;
            sessions_done++;
        endfunction

        function void start_flush(flush_act_t act);
            phase = PH_FLUSH;
            silence = '0;
            after_flush = act;
        endfunction

        function void solicit();
            if (retries_left == 0) begin
                start_flush(AF_RETRY);
                return;
            end
            emit(KIND_SEND, reply_byte, 10'd0, ST_OK, 32'd0);
            phase = PH_WAIT_START;
            silence = '0;
        endfunction

        function void three_cans();
            repeat (3) emit(KIND_SEND, B_CAN, 10'd0, ST_OK, 32'd0);
        endfunction

        function void flush_done();
            flush_act_t act;
            act = after_flush;
            after_flush = AF_NONE;
            case (act)
                AF_SOLICIT: solicit();
                AF_EOT: begin
                    emit(KIND_SEND, B_ACK, 10'd0, ST_OK, 32'd0);
                    finish(ST_OK);
                end
                AF_REMOTE: begin
                    emit(KIND_SEND, B_ACK, 10'd0, ST_OK, 32'd0);
                    finish(ST_REMOTE);
                end
                AF_SYNC: begin
                    three_cans();
                    finish(ST_SYNC);
                end
                AF_RETRY: begin
                    three_cans();
                    finish(ST_RETRY);
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void abort_packet();
            emit(KIND_DISCARD, 8'd0, 10'd0, ST_OK, 32'd0);
            if (retries_left > 0) retries_left--;
            reply_byte = B_NAK;
            start_flush(AF_SOLICIT);
        endfunction

        function int packet_len();
            return long_packet ? LONG_PACKET_BYTES : SHORT_PACKET_BYTES;
        endfunction

        function void begin_packet(logic is_long);
            long_packet = is_long;
            if (reply_byte == B_SOLICIT) crc_mode = 1'b1;
            byte_pos = '0;
            crc_acc = '0;
            sum_acc = '0;
            rx_check = '0;
            seq_byte = '0;
            seq_comp = '0;
            silence = '0;
            phase = PH_PACKET;
        endfunction

        function void end_packet();
            logic seq_ok, chk_ok;
            logic [32:0] sum;
            seq_ok = (seq_byte == ~seq_comp);
            chk_ok = crc_mode ? (crc_acc == rx_check) : (sum_acc == rx_check[7:0]);
            if (!(seq_ok && chk_ok)) begin
                abort_packet();
                return;
            end
            if (seq_byte == expected_seq) begin
                emit(KIND_COMMIT, 8'd0, 10'd0, ST_OK, 32'd0);
                sum = {1'b0, byte_total} + 33'(packet_len());
                byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                expected_seq = expected_seq + 8'd1;
                retries_left = retry_limit;
                reply_byte = B_ACK;
                solicit();
            end else if (seq_byte == expected_seq - 8'd1) begin
                emit(KIND_DISCARD, 8'd0, 10'd0, ST_OK, 32'd0);
                reply_byte = B_ACK;
                solicit();
            end else begin
                emit(KIND_DISCARD, 8'd0, 10'd0, ST_OK, 32'd0);
                start_flush(AF_SYNC);
            end
        endfunction

        function void on_byte(logic [7:0] b);
            int pk;
            int pos;
            case (phase)
                PH_WAIT_START: begin
                    silence = '0;
                    if (b == B_SOH) begin_packet(1'b0);
                    else if (b == B_STX && allow_long) begin_packet(1'b1);
                    else if (b == B_EOT) start_flush(AF_EOT);
                    else if (b == B_CAN) phase = PH_WAIT_CAN2;
                    else finish(ST_UNEXPEC);
                end
                PH_WAIT_CAN2: begin
                    silence = '0;
                    if (b == B_CAN) start_flush(AF_REMOTE);
                    else finish(ST_UNEXPEC);
                end
                PH_PACKET: begin
                    silence = '0;
                    pk = packet_len();
                    pos = byte_pos;
                    if (pos == 0) seq_byte = b;
                    else if (pos == 1) seq_comp = b;
                    else if (pos < pk + 2) begin
                        emit(KIND_PAYLOAD, b, 10'(pos - 2), ST_OK, 32'd0);
                        crc_acc = crc_next(crc_acc, b);
                        sum_acc = sum_acc + b;
                    end else begin
                        rx_check = {rx_check[7:0], b};
                    end
                    byte_pos = byte_pos + 11'd1;
                    if (int'(byte_pos) >= pk + 3 + int'(crc_mode)) end_packet();
                end
                PH_FLUSH: silence = '0;
                default: ;
            endcase
        endfunction

        function void on_tick();
            if (phase == PH_IDLE) return;
            if (silence < 8'd255) silence++;
            if (silence < timeout_ticks) return;
            silence = '0;
            case (phase)
                PH_WAIT_START: begin
                    if (retries_left > 0) retries_left--;
                    solicit();
                end
                PH_WAIT_CAN2: finish(ST_UNEXPEC);
                PH_PACKET: abort_packet();
                PH_FLUSH: flush_done();
                default: ;
            endcase
        endfunction

        // work out the results of one accepted input word
        function void note_input(in_word_t w);
            step_q.delete();
            case (w.op)
                OP_START: begin
                    clear_session();
                    solicit();
                end
                OP_BYTE: on_byte(w.rx_byte);
                OP_TICK: on_tick();
                default: ;
            endcase
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            checked++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.kind !== exp_w.kind)
                report("kind", exp_w.kind, got.kind);
            if (got.value !== exp_w.value)
                report("value", exp_w.value, got.value);
            if (got.offset !== exp_w.offset)
                report("offset", exp_w.offset, got.offset);
            if (got.status !== exp_w.status)
                report("status", exp_w.status, got.status);
            if (got.total_bytes !== exp_w.total_bytes)
                report("total_bytes", exp_w.total_bytes, got.total_bytes);
            if (got.last !== exp_w.last)
                report("last", exp_w.last, got.last);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, exp_v, got_v);
            errors++;
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    xmodem_crc_receiver_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    xmodem_scoreboard sb = new();
    int words_sent = 0;
    int cycles = 0;
    int word_budget = 0;
    bit steady = 1'b0;
    int stall_left = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
            stall_left = steady ? 0 : $urandom_range(0, 6);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // offer one word after a random gap and wait for it to be taken
    task automatic send_word(logic [1:0] op, logic [7:0] b);
        in_word_t w;
        int gap;
        w.op = op;
        w.rx_byte = b;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(OP_TICK, 8'($urandom()));
    endtask

    // hold the sender until every expected word is out, then let the core settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] tmo, logic [6:0] retry, logic long_ok);
        wait_drained();
        write_cfg(REG_TIMEOUT, tmo);
        write_cfg(REG_RETRY, {1'b0, retry});
        write_cfg(REG_LONG, {7'd0, long_ok});
    endtask

    // tick until the flush or the wait ends
    task automatic tick_out(phase_t ph);
        int guard;
        guard = 0;
        while (sb.phase == ph && guard < 300) begin
            send_word(OP_TICK, 8'($urandom()));
            guard++;
        end
    endtask

    // one packet; mode 0 good, 1 bad check, 2 bad complement, 3 cut short
    task automatic send_packet(logic [7:0] seq, logic is_long, int mode);
        logic [15:0] crc;
        logic [7:0] sum, b;
        int len;
        len = is_long ? LONG_PACKET_BYTES : SHORT_PACKET_BYTES;
        send_word(OP_BYTE, is_long ? B_STX : B_SOH);
        if (sb.phase != PH_PACKET) return;
        send_word(OP_BYTE, seq);
        send_word(OP_BYTE, mode == 2 ? seq : ~seq);
        crc = '0;
        sum = '0;
        for (int i = 0; i < len; i++) begin
            if (mode == 3 && i == 5) begin
                tick_out(PH_PACKET);
                return;
            end
            b = 8'($urandom());
            send_word(OP_BYTE, b);
            crc = sb.crc_next(crc, b);
            sum = sum + b;
        end
        if (mode == 1) begin
            crc = crc ^ 16'h0001;
            sum = sum ^ 8'h80;
        end
        if (sb.crc_mode) begin
            send_word(OP_BYTE, crc[15:8]);
            send_word(OP_BYTE, crc[7:0]);
        end else begin
            send_word(OP_BYTE, sum);
        end
    endtask

    // random session: cheap damage and noise, whole packets only when the budget allows
    task automatic run_session();
        int npk, r;
        logic want_long;
        send_word(OP_START, 8'($urandom()));
        npk = $urandom_range(1, 3);
        for (int p = 0; p < npk; p++) begin
            if (sb.phase == PH_FLUSH) tick_out(PH_FLUSH);
            if (sb.phase != PH_WAIT_START) return;
            want_long = sb.allow_long && $urandom_range(0, 1) == 0;
            // a whole packet costs about 140 words
            if (words_sent + 140 <= word_budget) r = $urandom_range(0, 19);
            else r = $urandom_range(17, 19);
            if (r < 13) send_packet(sb.expected_seq, 1'b0, 0);
            else if (r == 13) send_packet(sb.expected_seq - 8'd1, 1'b0, 0);
            else if (r == 14) send_packet(sb.expected_seq, 1'b0, 1);
            else if (r == 15) send_packet(sb.expected_seq, 1'b0, 2);
            else if (r == 16) send_packet(sb.expected_seq + 8'd7, 1'b0, 0);
            else if (r == 17) send_packet(sb.expected_seq, want_long, 3);
            else if (r == 18) send_word(OP_BYTE, 8'($urandom()));
            else send_ticks(int'(sb.timeout_ticks));
        end
        if (sb.phase == PH_FLUSH) tick_out(PH_FLUSH);
        if (sb.phase != PH_WAIT_START) return;
        r = $urandom_range(0, 4);
        if (r <= 1) send_word(OP_BYTE, B_EOT);
        else if (r == 2) begin
            send_word(OP_BYTE, B_CAN);
            send_word(OP_BYTE, B_CAN);
        end else if (r == 3) begin
            send_word(OP_BYTE, B_CAN);
            send_word(OP_BYTE, 8'($urandom()));
        end
        tick_out(PH_FLUSH);
        tick_out(PH_WAIT_CAN2);
    endtask

    task automatic random_phase(int n_words);
        word_budget = words_sent + n_words;
        while (words_sent < word_budget) begin
            steady = ($urandom_range(0, 3) == 0);
            run_session();
        end
        steady = 1'b0;
    endtask

    initial begin
        sb.reset_all();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short timeout so each wait ends after two ticks
        write_cfg(REG_TIMEOUT, 8'd2);
        write_cfg(REG_RETRY, 8'd3);
        write_cfg(REG_LONG, 8'd1);
        write_cfg(2'd3, 8'hFF);
        send_word(2'd3, 8'hFF);
        send_word(OP_BYTE, 8'h55);
        send_word(OP_TICK, 8'h00);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_START, 8'hAA);
        send_word(OP_BYTE, B_CAN);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_CAN);
        send_ticks(2);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_CAN);
        send_word(OP_BYTE, B_CAN);
        send_ticks(2);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_EOT);
        send_ticks(2);
        send_word(OP_START, 8'h00);
        send_ticks(2);
        send_word(OP_START, 8'h00);

        // sender pauses for the result side to catch up, then one whole packet
        set_config(8'd3, 7'd4, 1'b1);
        send_word(OP_START, 8'h00);
        send_packet(8'd1, 1'b0, 0);
        send_word(OP_BYTE, B_EOT);
        tick_out(PH_FLUSH);
        random_phase(20);

        // zero timeout and zero retries: solicit flushes straight into cancel
        set_config(8'd0, 7'd0, 1'b1);
        send_word(OP_START, 8'h00);
        send_ticks(2);

        // widest timeout, most retries, long packets refused
        set_config(8'd255, 7'd127, 1'b0);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_STX);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_EOT);
        send_word(OP_START, 8'h00);

        // random settings including one retry only
        set_config(8'd1, 7'd1, 1'b0);
        random_phase(10);
        set_config(8'($urandom_range(1, 6)), 7'($urandom_range(1, 127)), 1'b1);
        random_phase(10);

        // reset values of the registers
        set_config(8'd100, 7'd32, 1'b1);
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, B_CAN);
        send_word(OP_BYTE, 8'h41);

        wait_drained();
        $display("%0d input words driven over %0d sessions, %0d result words checked",
                 words_sent, sb.sessions_done, sb.checked);
        $display("covered a whole crc packet, cut-short and refused packets, cancels, timeouts");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
